// ===== rtl/lscl_pkg.sv =====
// Lookahead soft-clip limiter: shared constants, register codes and state types.
// No dependencies; imported by lscl_cfg_if, the shaper, the core and the testbench modules.
`timescale 1ns / 1ps

package lscl_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CEIL_W     = 16;
	localparam int LOOK_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd1;

	localparam logic [CEIL_W-1:0] CEIL_RESET = 16'd61874;
	localparam logic [LOOK_W-1:0] LOOK_RESET = 6'd24;

	// gain quotient u is Q1.30, never above one
	localparam int U_FRAC    = 30;
	localparam int U_W       = U_FRAC + 1;
	localparam logic [U_W-1:0] THIRD_Q30 = 31'd357913941;

	// radix-8 restoring divider
	localparam int DIV_BITS  = 3;
	localparam int DIV_STEPS = U_FRAC / DIV_BITS;
	localparam int DIV_CNT_W = 4;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CHECK,
		SEQ_READ,
		SEQ_SHAPE,
		SEQ_EMIT
	} seq_state_t;

	typedef enum logic [2:0] {
		SHP_IDLE,
		SHP_DIV,
		SHP_SQR,
		SHP_CUBE,
		SHP_THIRD,
		SHP_SCALE,
		SHP_ROUND,
		SHP_DONE
	} shp_state_t;

endpackage

// ===== rtl/lscl_ifs.sv =====
// Valid/ready channel interfaces of the limiter: sample input, result output, register writes.
// Depends on lscl_pkg.
`timescale 1ns / 1ps

interface lscl_in_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_end;

	modport source (output valid, sample_in, block_end, input ready);
	modport sink   (input valid, sample_in, block_end, output ready);
endinterface

interface lscl_out_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          run_last;
	logic                          block_last;

	modport source (output valid, sample_out, run_last, block_last, input ready);
	modport sink   (input valid, sample_out, run_last, block_last, output ready);
endinterface

interface lscl_cfg_if import lscl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lscl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lscl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lscl_shaper.sv =====
// Gain and soft-clip datapath: x / max(|a|, ceiling) by radix-8 division, then the cubic
// u - u^3/3, scaled by the ceiling, rounded and saturated. Depends on lscl_pkg.
`timescale 1ns / 1ps

module lscl_shaper import lscl_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] x,
	input  logic [SAMPLE_BITS-1:0] a,
	input  logic [CEIL_W-1:0]      ceiling,
	output logic                   done,
	output logic [SAMPLE_BITS-1:0] y
);

	localparam int NW = SAMPLE_BITS + 16;
	localparam int MW = 2 * U_W;
	localparam int PW = U_W + CEIL_W;
	localparam int RS = PW - SAMPLE_BITS;

	shp_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] ax, al;
	logic [NW-1:0]          n_w, dl_w, cs_w, d_w;
	logic                   one_w;

	logic [NW-1:0]          r_q, d_q;
	logic [U_W-1:0]         u_q, sq_q, cube_q, t_q;
	logic [PW-1:0]          prod_q;
	logic [CEIL_W-1:0]      ceil_q;
	logic                   neg_q, zero_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [SAMPLE_BITS-1:0] y_q;

	logic [NW:0]            rr;
	logic [NW-1:0]          r_nx;
	logic [U_W-1:0]         u_nx;

	logic [MW-1:0]          sq_p, cube_p, third_p;
	logic [PW-1:0]          scale_p;
	logic [U_W-1:0]         f_w;
	logic [PW:0]            sum_w;
	logic [SAMPLE_BITS:0]   o_w;
	logic [SAMPLE_BITS-1:0] o_sat;

	assign ax   = x[SAMPLE_BITS-1] ? (~x + SAMPLE_BITS'(1)) : x;
	assign al   = a[SAMPLE_BITS-1] ? (~a + SAMPLE_BITS'(1)) : a;
	assign n_w  = {ax, 16'h0000};
	assign dl_w = {al, 16'h0000};
	assign cs_w = {1'b0, ceiling, {(SAMPLE_BITS-1){1'b0}}};
	assign d_w  = (cs_w > dl_w) ? cs_w : dl_w;
	assign one_w = (n_w >= d_w);

	always_comb begin
		r_nx = r_q;
		u_nx = u_q;
		rr   = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			rr   = {r_nx, 1'b0};
			u_nx = {u_nx[U_W-2:0], 1'b0};
			if (rr >= {1'b0, d_q}) begin
				rr      = rr - {1'b0, d_q};
				u_nx[0] = 1'b1;
			end
			r_nx = rr[NW-1:0];
		end
	end

	assign sq_p    = MW'(u_q) * MW'(u_q);
	assign cube_p  = MW'(sq_q) * MW'(u_q);
	assign third_p = MW'(cube_q) * MW'(THIRD_Q30);
	assign f_w     = u_q - t_q;
	assign scale_p = PW'(f_w) * PW'(ceil_q);

	assign sum_w = {1'b0, prod_q} + ((PW+1)'(1) << (RS - 1));
	assign o_w   = sum_w[PW:RS];
	assign o_sat = (o_w > {2'b00, {(SAMPLE_BITS-1){1'b1}}})
		? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : o_w[SAMPLE_BITS-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			SHP_IDLE: begin
				if (start) begin
					state_d = one_w ? SHP_SQR : SHP_DIV;
				end
			end
			SHP_DIV: begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = SHP_SQR;
				end
			end
			SHP_SQR:   state_d = SHP_CUBE;
			SHP_CUBE:  state_d = SHP_THIRD;
			SHP_THIRD: state_d = SHP_SCALE;
			SHP_SCALE: state_d = SHP_ROUND;
			SHP_ROUND: state_d = SHP_DONE;
			SHP_DONE:  state_d = SHP_IDLE;
			default:   state_d = SHP_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == SHP_DONE);
		y    = y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SHP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SHP_IDLE: begin
				if (start) begin
					r_q    <= n_w;
					d_q    <= d_w;
					u_q    <= one_w ? (U_W'(1) << U_FRAC) : '0;
					cnt_q  <= '0;
					ceil_q <= ceiling;
					neg_q  <= x[SAMPLE_BITS-1];
					zero_q <= (ceiling == '0) || (ax == '0);
				end
			end
			SHP_DIV: begin
				r_q   <= r_nx;
				u_q   <= u_nx;
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			SHP_SQR:   sq_q   <= sq_p[U_FRAC+U_W-1:U_FRAC];
			SHP_CUBE:  cube_q <= cube_p[U_FRAC+U_W-1:U_FRAC];
			SHP_THIRD: t_q    <= third_p[U_FRAC+U_W-1:U_FRAC];
			SHP_SCALE: prod_q <= scale_p;
			SHP_ROUND: begin
				if (zero_q) begin
					y_q <= '0;
				end else begin
					y_q <= neg_q ? (SAMPLE_BITS'(0) - o_sat) : o_sat;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/lookahead_soft_clip_limiter_core.sv =====
// Lookahead peak limiter with cubic soft clip, one channel: delay store, sequencer, outputs.
// Depends on lscl_pkg, lscl_ifs, lscl_ram and lscl_shaper.
//
//   channel  | dir | word
//   samples  | in  | sample_in, block_end
//   results  | out | sample_out, run_last, block_last
//   cfg      | in  | index, data (0: ceiling_level, 1: lookahead_len)
//
// One input word at a time: each word is accepted, then checked; each released sample
// then passes the 10-step radix-8 divider (skipped when |x| reaches the limit) and the
// four registered multiplies of the shaper.
// Reset clears control and registers; the delay store needs no clearing pass.
// A stalled result holds in the output register; the sequencer waits behind it.
`timescale 1ns / 1ps

module lookahead_soft_clip_limiter_core import lscl_pkg::*; #(
	parameter int MAX_LOOKAHEAD = 64,
	parameter int SAMPLE_BITS   = 24
) (
	input  logic clk,
	input  logic arst_n,
	lscl_in_if.sink    samples,
	lscl_out_if.source results,
	lscl_cfg_if.sink   cfg
);

	localparam int AW = $clog2(MAX_LOOKAHEAD);
	localparam int CW = $clog2(MAX_LOOKAHEAD + 1);
	localparam int LW = (CW > LOOK_W) ? CW : LOOK_W;

	seq_state_t state_q, state_d;

	logic [CEIL_W-1:0]      ceil_q;
	logic [LOOK_W-1:0]      look_q;
	logic [AW-1:0]          oldest_q;
	logic [CW-1:0]          count_q;
	logic                   flush_q;
	logic [SAMPLE_BITS-1:0] res_q;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic                   out_run_last_q;
	logic                   out_block_last_q;

	logic [LW-1:0]          look_wide;
	logic [CW-1:0]          look_eff, keep, off, count_m1;
	logic [AW:0]            wsum, rsum;
	logic [AW-1:0]          waddr, raddr_a;
	logic                   release_w, run_last_w, slot_free;

	logic                   accept, ram_we, shp_start, shp_done, emit;
	logic [SAMPLE_BITS-1:0] rdata_x, rdata_a, shp_y;

	assign look_wide = (LW'(look_q) > LW'(MAX_LOOKAHEAD - 1)) ? LW'(MAX_LOOKAHEAD - 1)
		: LW'(look_q);
	assign look_eff  = look_wide[CW-1:0];
	assign keep      = flush_q ? '0 : look_eff;
	assign count_m1  = count_q - CW'(1);
	assign off       = (look_eff > count_m1) ? count_m1 : look_eff;
	assign release_w = (count_q > keep);
	assign run_last_w = (count_m1 <= keep);

	assign wsum    = (AW+1)'(oldest_q) + (AW+1)'(count_q);
	assign waddr   = (wsum >= (AW+1)'(MAX_LOOKAHEAD)) ? AW'(wsum - (AW+1)'(MAX_LOOKAHEAD))
		: wsum[AW-1:0];
	assign rsum    = (AW+1)'(oldest_q) + (AW+1)'(off);
	assign raddr_a = (rsum >= (AW+1)'(MAX_LOOKAHEAD)) ? AW'(rsum - (AW+1)'(MAX_LOOKAHEAD))
		: rsum[AW-1:0];

	assign slot_free = !out_valid_q || results.ready;

	lscl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LOOKAHEAD)) u_ram_x (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (samples.sample_in),
		.raddr (oldest_q),
		.rdata (rdata_x)
	);

	lscl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LOOKAHEAD)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (samples.sample_in),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	lscl_shaper #(.SAMPLE_BITS(SAMPLE_BITS)) u_shaper (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (shp_start),
		.x       (rdata_x),
		.a       (rdata_a),
		.ceiling (ceil_q),
		.done    (shp_done),
		.y       (shp_y)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (samples.valid) begin
					state_d = SEQ_CHECK;
				end
			end
			SEQ_CHECK: state_d = release_w ? SEQ_READ : SEQ_IDLE;
			SEQ_READ:  state_d = SEQ_SHAPE;
			SEQ_SHAPE: begin
				if (shp_done) begin
					state_d = SEQ_EMIT;
				end
			end
			SEQ_EMIT: begin
				if (slot_free) begin
					state_d = SEQ_CHECK;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = (state_q == SEQ_IDLE);
		accept        = samples.valid && (state_q == SEQ_IDLE);
		ram_we        = accept;
		shp_start     = (state_q == SEQ_READ);
		emit          = (state_q == SEQ_EMIT) && slot_free;
		cfg.ready     = 1'b1;
	end

	assign results.valid      = out_valid_q;
	assign results.sample_out = out_sample_q;
	assign results.run_last   = out_run_last_q;
	assign results.block_last = out_block_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			ceil_q      <= CEIL_RESET;
			look_q      <= LOOK_RESET;
			oldest_q    <= '0;
			count_q     <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_CEILING:   ceil_q <= cfg.data[CEIL_W-1:0];
					REG_LOOKAHEAD: look_q <= cfg.data[LOOK_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				count_q <= count_q + CW'(1);
				flush_q <= samples.block_end;
			end
			if ((state_q == SEQ_CHECK) && !release_w && (count_q == '0)) begin
				oldest_q <= '0;
			end
			if (emit) begin
				count_q  <= count_m1;
				oldest_q <= (oldest_q == AW'(MAX_LOOKAHEAD - 1)) ? '0 : oldest_q + AW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == SEQ_SHAPE) && shp_done) begin
			res_q <= shp_y;
		end
		if (emit) begin
			out_sample_q     <= res_q;
			out_run_last_q   <= run_last_w;
			out_block_last_q <= run_last_w && flush_q;
		end
	end

endmodule

// ===== rtl/lscl_chk.sv =====
// Port-level checker for the limiter core, attached to it by the bind below.
// Depends on lookahead_soft_clip_limiter_core for the bind target.
`timescale 1ns / 1ps

module lscl_chk #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_sample,
	input logic                   out_run_last,
	input logic                   out_block_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample)
			&& $stable(out_run_last) && $stable(out_block_last))
		else $error("result word changed while stalled");

	a_block_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_block_last |-> out_run_last)
		else $error("block end without run end");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous word still in work");

	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_run_last |-> !in_ready)
		else $error("input taken before run finished");

endmodule

bind lookahead_soft_clip_limiter_core lscl_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_lscl_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_sample     (results.sample_out),
	.out_run_last   (results.run_last),
	.out_block_last (results.block_last)
);

// ===== tb/sv/lscl_limiter_checker.sv =====
// Checker for the lookahead soft-clip limiter: watches the sample, result and register
// channels, predicts every released sample and compares it word by word.
// Depends on lscl_pkg.
`timescale 1ns / 1ps

module lscl_limiter_checker import lscl_pkg::*; #(
	parameter int MAX_LOOKAHEAD = 64,
	parameter int SAMPLE_BITS   = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   samples_valid,
	input  logic                   samples_ready,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic                   block_end,
	input  logic                   results_valid,
	input  logic                   results_ready,
	input  logic [SAMPLE_BITS-1:0] sample_out,
	input  logic                   run_last,
	input  logic                   block_last,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     outstanding,
	output int                     fail_count,
	output int                     results_checked
);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   run_last;
		logic                   block_last;
	} limiter_word_t;

	logic [SAMPLE_BITS-1:0] delay_line [MAX_LOOKAHEAD];
	int                     held_count;
	int                     head_ptr;
	logic [CEIL_W-1:0]      ceiling_reg;
	logic [LOOK_W-1:0]      lookahead_reg;
	limiter_word_t          expected_words [$];
	limiter_word_t          want;
	int                     errors;
	int                     checked;

	// gain, cubic shaping and rescale of one released sample against its lookahead sample
	function automatic logic [SAMPLE_BITS-1:0] soft_clip_sample(
		input logic [SAMPLE_BITS-1:0] x,
		input logic [SAMPLE_BITS-1:0] ahead,
		input logic [CEIL_W-1:0]      ceil
	);
		logic                   x_neg;
		logic [SAMPLE_BITS-1:0] mag_x;
		logic [SAMPLE_BITS-1:0] mag_a;
		logic [SAMPLE_BITS-1:0] mag_o;
		logic [63:0]            num, den, ceil_den, cc, rem, u, u2, u3, third, f, o;

		x_neg = x[SAMPLE_BITS-1];
		mag_x = x_neg ? -x : x;
		mag_a = ahead[SAMPLE_BITS-1] ? -ahead : ahead;
		if (ceil == '0 || mag_x == '0)
			return '0;
		cc = ceil;
		num = mag_x;
		num = num << 16;
		den = mag_a;
		den = den << 16;
		ceil_den = cc << (SAMPLE_BITS - 1);
		if (ceil_den > den)
			den = ceil_den;
		if (num >= den) begin
			u = 64'd1 << U_FRAC;
		end else begin
			rem = num;
			u = '0;
			for (int i = 0; i < U_FRAC; i++) begin
				rem = rem << 1;
				u = u << 1;
				if (rem >= den) begin
					rem = rem - den;
					u = u | 64'd1;
				end
			end
		end
		u2 = (u * u) >> U_FRAC;
		u3 = (u2 * u) >> U_FRAC;
		third = (u3 * 64'(THIRD_Q30)) >> U_FRAC;
		f = u - third;
		o = (f * cc + (64'd1 << (46 - SAMPLE_BITS))) >> (47 - SAMPLE_BITS);
		if (o > ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1))
			o = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		mag_o = o[SAMPLE_BITS-1:0];
		return x_neg ? -mag_o : mag_o;
	endfunction

	// push one sample into the delay line and queue every word it releases
	task automatic predict_releases(input logic [SAMPLE_BITS-1:0] sample, input logic flush);
		int            look;
		int            keep;
		int            off;
		limiter_word_t word;

		look = (lookahead_reg > MAX_LOOKAHEAD - 1) ? MAX_LOOKAHEAD - 1 : lookahead_reg;
		if (held_count < MAX_LOOKAHEAD) begin
			delay_line[(head_ptr + held_count) % MAX_LOOKAHEAD] = sample;
			held_count++;
		end
		keep = flush ? 0 : look;
		while (held_count > keep) begin
			off = (look > held_count - 1) ? held_count - 1 : look;
			word.sample = soft_clip_sample(delay_line[head_ptr],
				delay_line[(head_ptr + off) % MAX_LOOKAHEAD], ceiling_reg);
			word.run_last = (held_count == keep + 1);
			word.block_last = word.run_last && flush;
			expected_words.insert(expected_words.size(), word);
			head_ptr = (head_ptr + 1) % MAX_LOOKAHEAD;
			held_count--;
		end
		if (held_count == 0)
			head_ptr = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LOOKAHEAD; i++)
				delay_line[i] = '0;
			held_count = 0;
			head_ptr = 0;
			ceiling_reg = CEIL_RESET;
			lookahead_reg = LOOK_RESET;
			expected_words.delete();
			errors = 0;
			checked = 0;
			outstanding <= 0;
			fail_count <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CEILING)
					ceiling_reg = cfg_data[CEIL_W-1:0];
				else if (cfg_index == REG_LOOKAHEAD)
					lookahead_reg = cfg_data[LOOK_W-1:0];
			end
			if (samples_valid && samples_ready)
				predict_releases(sample_in, block_end);
			if (results_valid && results_ready) begin
				checked++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, sample_out %0d with nothing expected",
						$time, $signed(sample_out));
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (sample_out !== want.sample) begin
						$display("%0t: sample_out expected %0d got %0d",
							$time, $signed(want.sample), $signed(sample_out));
						errors++;
					end
					if (run_last !== want.run_last) begin
						$display("%0t: run_last expected %0b got %0b",
							$time, want.run_last, run_last);
						errors++;
					end
					if (block_last !== want.block_last) begin
						$display("%0t: block_last expected %0b got %0b",
							$time, want.block_last, block_last);
						errors++;
					end
				end
			end
			outstanding <= expected_words.size();
			fail_count <= errors;
			results_checked <= checked;
		end
	end

endmodule

// ===== tb/sv/tb_lookahead_soft_clip_limiter_core.sv =====
// Testbench top for lookahead_soft_clip_limiter_core: clock, reset, register writes,
// sample stimulus with random gaps and result stalls, watchdog and verdict.
// Depends on lscl_pkg, lscl_ifs, the core and lscl_limiter_checker.
`timescale 1ns / 1ps

module tb_lookahead_soft_clip_limiter_core import lscl_pkg::*; ();

	localparam int MAX_LOOKAHEAD  = 64;
	localparam int SAMPLE_BITS    = 24;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_WORDS    = 38;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [SAMPLE_BITS-1:0] FULL_POS = 24'h7FFFFF;
	localparam logic [SAMPLE_BITS-1:0] FULL_NEG = 24'h800000;

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	int   stall_left;
	int   quiet_cycles;
	int   words_sent;
	int   reg_writes;
	int   outstanding;
	int   fail_count;
	int   results_checked;
	logic any_word;

	lscl_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
	lscl_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) results_ch ();
	lscl_cfg_if                              cfg_ch ();

	lookahead_soft_clip_limiter_core #(
		.MAX_LOOKAHEAD(MAX_LOOKAHEAD),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	lscl_limiter_checker #(
		.MAX_LOOKAHEAD(MAX_LOOKAHEAD),
		.SAMPLE_BITS(SAMPLE_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.samples_valid(samples_ch.valid),
		.samples_ready(samples_ch.ready),
		.sample_in(samples_ch.sample_in),
		.block_end(samples_ch.block_end),
		.results_valid(results_ch.valid),
		.results_ready(results_ch.ready),
		.sample_out(results_ch.sample_out),
		.run_last(results_ch.run_last),
		.block_last(results_ch.block_last),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_index(cfg_ch.index),
		.cfg_data(cfg_ch.data),
		.outstanding(outstanding),
		.fail_count(fail_count),
		.results_checked(results_checked)
	);

	always #2 clk = ~clk;

	assign any_word = (samples_ch.valid && samples_ch.ready) ||
		(results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready);

	always @(posedge clk) begin
		if (!arst_n || any_word) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("lookahead_soft_clip_limiter_core test failed");
				$finish;
			end
		end
	end

	// result side: random stall bursts while idle_on is set
	always @(posedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			results_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			results_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		reg_writes++;
	endtask

	task automatic set_limits(input logic [CFG_DATA_W-1:0] ceil,
		input logic [CFG_DATA_W-1:0] look);
		write_reg(REG_CEILING, ceil);
		write_reg(REG_LOOKAHEAD, look);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_word(input logic [SAMPLE_BITS-1:0] sample, input logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.sample_in <= sample;
		samples_ch.block_end <= last;
		do @(posedge clk); while (!samples_ch.ready);
		words_sent++;
	endtask

	// hold the sender until every released word is back, then let the sequencer settle
	task automatic wait_for_results();
		samples_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FULL_POS;
			2: return FULL_NEG;
			3: return SAMPLE_BITS'(32'd0 - $urandom_range(1, 4095));
			4: return SAMPLE_BITS'($urandom_range(1, 4095));
			default: return r[SAMPLE_BITS-1:0];
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_ceiling();
		case ($urandom_range(0, 7))
			0: return 16'd16462;
			1: return 16'd64786;
			2: return CFG_DATA_W'($urandom_range(0, 65535));
			default: return CFG_DATA_W'($urandom_range(16462, 64786));
		endcase
	endfunction

	// upper data bits are random; only the low six reach the register
	function automatic logic [CFG_DATA_W-1:0] pick_lookahead();
		logic [LOOK_W-1:0] look;
		logic [31:0]       r;
		r = $urandom;
		case ($urandom_range(0, 5))
			0: look = '0;
			1: look = '1;
			2, 3: look = LOOK_W'($urandom_range(1, 8));
			default: look = LOOK_W'($urandom_range(0, 63));
		endcase
		return {r[CFG_DATA_W-LOOK_W-1:0], look};
	endfunction

	initial begin
		int   blk_left;
		logic last;

		arst_n = 1'b0;
		idle_on = 1'b1;
		words_sent = 0;
		reg_writes = 0;
		blk_left = 0;
		samples_ch.valid = 1'b0;
		samples_ch.sample_in = '0;
		samples_ch.block_end = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// full-scale ceiling, no lookahead: each word comes straight back
		set_limits(16'hFFFF, 16'd0);
		send_word(FULL_POS, 1'b0);
		send_word(FULL_NEG, 1'b0);
		send_word('0, 1'b0);
		send_word(24'd1, 1'b0);
		send_word(24'hFFFFFF, 1'b1);
		wait_for_results();

		// low ceiling, loud input clamps; then shorten lookahead with words held
		set_limits(16'd16462, 16'd3);
		send_word(FULL_POS, 1'b0);
		send_word(FULL_NEG, 1'b0);
		send_word(24'h000100, 1'b0);
		send_word(24'hFFFF00, 1'b0);
		wait_for_results();
		set_limits(16'd16462, 16'd1);
		send_word(24'h400000, 1'b0);
		send_word(24'hC00000, 1'b1);
		wait_for_results();

		// zero ceiling
		set_limits(16'd0, 16'd2);
		send_word(FULL_POS, 1'b0);
		send_word(24'h123456, 1'b0);
		send_word(FULL_NEG, 1'b0);
		send_word(24'd1, 1'b1);
		wait_for_results();

		// unused indexes, longest lookahead, flush before the lookahead fills
		write_reg(REG_SPARE_2, 16'h1234);
		write_reg(REG_SPARE_3, 16'hFFFF);
		set_limits(16'd64786, 16'hFFFF);
		send_word(24'h300000, 1'b0);
		send_word(24'hD00000, 1'b0);
		send_word('0, 1'b0);
		send_word(FULL_POS, 1'b1);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1)
				idle_on = 1'b0;
			wait_for_results();
			set_limits(pick_ceiling(), pick_lookahead());
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (blk_left == 0)
					blk_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
						$urandom_range(4, 80);
				last = (blk_left == 1) || ($urandom_range(0, 31) == 0) ||
					(phase == RANDOM_PHASES - 1 && k == PHASE_WORDS - 1);
				send_word(pick_sample(), last);
				blk_left = last ? 0 : blk_left - 1;
			end
		end

		wait_for_results();
		$display("Sent %0d samples over %0d register writes and checked %0d results;",
			words_sent, reg_writes, results_checked);
		$display("ceilings zero to full scale, lookahead 0 to 63, flushes, stalls both sides.");
		if (fail_count == 0 && outstanding == 0)
			$display("lookahead_soft_clip_limiter_core test passed");
		else
			$display("lookahead_soft_clip_limiter_core test failed");
		$finish;
	end

endmodule
